>>> rtl/core/hhs_pkg.sv
// Shared types and constants for the heater handle supervisor.
package hhs_pkg;

  // Counter and sensor widths
  localparam int CNT_W  = 16;
  localparam int SENS_W = 10;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_OPERATING_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_LOW_TEMP_LIMIT   = 3'd1;
  localparam logic [IDX_W-1:0] CFG_OVER_TEMP_LIMIT  = 3'd2;
  localparam logic [IDX_W-1:0] CFG_LOW_WIND_LIMIT   = 3'd3;
  localparam logic [IDX_W-1:0] CFG_ERROR_TIMEOUT    = 3'd4;
  localparam logic [IDX_W-1:0] CFG_SLEEP_TIMEOUT    = 3'd5;
  localparam logic [IDX_W-1:0] CFG_SLEEP_TEMP_LIMIT = 3'd6;

  // Register reset values
  localparam logic [SENS_W-1:0] RST_LOW_TEMP   = SENS_W'(100);
  localparam logic [SENS_W-1:0] RST_OVER_TEMP  = SENS_W'(500);
  localparam logic [SENS_W-1:0] RST_LOW_WIND   = SENS_W'(10);
  localparam logic [CNT_W-1:0]  RST_ERR_TO     = CNT_W'(1000);
  localparam logic [CNT_W-1:0]  RST_SLEEP_TO   = CNT_W'(60000);
  localparam logic [SENS_W-1:0] RST_SLEEP_TEMP = SENS_W'(70);

  // Operating modes
  localparam logic OPMODE_NORMAL = 1'b0;
  localparam logic OPMODE_CODE   = 1'b1;

  // Heat modes
  localparam logic [1:0] HEAT_NORMAL = 2'd0;
  localparam logic [1:0] HEAT_ENABLE = 2'd1;

  // Fault codes
  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_OVER = 2'd1;
  localparam logic [1:0] FAULT_LOW  = 2'd2;
  localparam logic [1:0] FAULT_FAN  = 2'd3;

  // Handle states
  localparam logic ST_ASLEEP = 1'b0;
  localparam logic ST_ACTIVE = 1'b1;

  typedef struct packed {
    logic              operating_mode;
    logic [SENS_W-1:0] low_temp_limit;
    logic [SENS_W-1:0] over_temp_limit;
    logic [SENS_W-1:0] low_wind_limit;
    logic [CNT_W-1:0]  error_timeout;
    logic [CNT_W-1:0]  sleep_timeout;
    logic [SENS_W-1:0] sleep_temp_limit;
  } hhs_cfg_t;

  typedef struct packed {
    logic              handle_lifted;
    logic [SENS_W-1:0] temperature;
    logic [SENS_W-1:0] airflow;
    logic [1:0]        heat_mode;
    logic              code_session_active;
    logic              clear_fault;
  } hhs_item_t;

  typedef struct packed {
    logic       handle_active;
    logic [1:0] fault_code;
    logic       long_beep;
    logic       last_was_working;
    logic [1:0] mode_after;
  } hhs_result_t;

  // Saturating increment of a tick counter
  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    bump = (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
  endfunction

endpackage

>>> rtl/core/hhs_cfg_regs.sv
// Configuration register file for the heater handle supervisor.
module hhs_cfg_regs
  import hhs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output hhs_cfg_t         cfg
);

  // Register writes, truncated to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.operating_mode   <= OPMODE_NORMAL;
      cfg.low_temp_limit   <= RST_LOW_TEMP;
      cfg.over_temp_limit  <= RST_OVER_TEMP;
      cfg.low_wind_limit   <= RST_LOW_WIND;
      cfg.error_timeout    <= RST_ERR_TO;
      cfg.sleep_timeout    <= RST_SLEEP_TO;
      cfg.sleep_temp_limit <= RST_SLEEP_TEMP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OPERATING_MODE:   cfg.operating_mode   <= cfg_data[0];
        CFG_LOW_TEMP_LIMIT:   cfg.low_temp_limit   <= cfg_data[SENS_W-1:0];
        CFG_OVER_TEMP_LIMIT:  cfg.over_temp_limit  <= cfg_data[SENS_W-1:0];
        CFG_LOW_WIND_LIMIT:   cfg.low_wind_limit   <= cfg_data[SENS_W-1:0];
        CFG_ERROR_TIMEOUT:    cfg.error_timeout    <= cfg_data[CNT_W-1:0];
        CFG_SLEEP_TIMEOUT:    cfg.sleep_timeout    <= cfg_data[CNT_W-1:0];
        CFG_SLEEP_TEMP_LIMIT: cfg.sleep_temp_limit <= cfg_data[SENS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/hhs_tick_logic.sv
// Supervisor state and per-tick update logic.
module hhs_tick_logic
  import hhs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  hhs_cfg_t    cfg,
  input  hhs_item_t   item,
  output hhs_result_t res
);

  logic             handle_state, handle_state_next;
  logic [1:0]       fault_state, fault_state_next;
  logic [CNT_W-1:0] error_ticks, error_ticks_next;
  logic [CNT_W-1:0] sleep_ticks, sleep_ticks_next;
  logic             previous_state, previous_state_next;
  logic             beep;
  logic [1:0]       mode;

  logic             low, over, wind_low;
  logic [CNT_W-1:0] err_inc, err_mid, sleep_inc, half_to;
  logic [1:0]       fault_clr;

  // Shared compares, counter increments and the cleared fault state
  assign low       = item.temperature <= cfg.low_temp_limit;
  assign over      = item.temperature >= cfg.over_temp_limit;
  assign wind_low  = item.airflow < cfg.low_wind_limit;
  assign err_inc   = bump(error_ticks);
  assign sleep_inc = bump(sleep_ticks);
  assign half_to   = {1'b0, cfg.error_timeout[CNT_W-1:1]};
  assign fault_clr = item.clear_fault ? FAULT_NONE : fault_state;

  // Next state for one tick
  always_comb begin
    handle_state_next   = handle_state;
    fault_state_next    = fault_clr;
    error_ticks_next    = error_ticks;
    sleep_ticks_next    = sleep_ticks;
    previous_state_next = previous_state;
    beep                = 1'b0;
    mode                = item.heat_mode;
    err_mid             = err_inc;
    if (cfg.operating_mode == OPMODE_NORMAL) begin
      if (handle_state == ST_ASLEEP) begin
        // sleeping: wake on lift
        handle_state_next   = item.handle_lifted;
        previous_state_next = ST_ASLEEP;
        error_ticks_next    = '0;
      end else if (item.heat_mode == HEAT_NORMAL || item.heat_mode == HEAT_ENABLE) begin
        if (item.heat_mode == HEAT_ENABLE && !item.handle_lifted)
          mode = HEAT_NORMAL;
        if ((low || over) && item.handle_lifted) begin
          error_ticks_next = err_inc;
          if (over && err_inc >= half_to) begin
            fault_state_next    = FAULT_OVER;
            previous_state_next = ST_ACTIVE;
            error_ticks_next    = '0;
          end else if (err_inc >= cfg.error_timeout) begin
            if (low)
              fault_state_next = FAULT_LOW;
            else if (wind_low)
              fault_state_next = FAULT_FAN;
            previous_state_next = ST_ACTIVE;
            error_ticks_next    = '0;
          end
        end else begin
          error_ticks_next = '0;
          // docked and cool: count toward sleep
          if (!item.handle_lifted && item.temperature <= cfg.sleep_temp_limit) begin
            sleep_ticks_next = sleep_inc;
            if (sleep_inc > cfg.sleep_timeout) begin
              handle_state_next   = ST_ASLEEP;
              sleep_ticks_next    = '0;
              beep                = 1'b1;
              previous_state_next = ST_ACTIVE;
            end
          end
        end
      end
    end else if (item.code_session_active) begin
      // code operation: fault counter only, airflow checked too
      if ((low || over || wind_low) && item.handle_lifted) begin
        error_ticks_next = err_inc;
        if (over && !wind_low && err_inc >= half_to) begin
          fault_state_next    = FAULT_OVER;
          previous_state_next = ST_ACTIVE;
          err_mid             = '0;
          error_ticks_next    = '0;
        end
        if (err_mid >= cfg.error_timeout) begin
          if (low && !wind_low)
            fault_state_next = FAULT_LOW;
          else if (wind_low)
            fault_state_next = FAULT_FAN;
          previous_state_next = ST_ACTIVE;
          error_ticks_next    = '0;
        end
      end else begin
        error_ticks_next = '0;
      end
    end
  end

  // Result word for this tick
  always_comb begin
    res.handle_active    = handle_state_next;
    res.fault_code       = fault_state_next;
    res.long_beep        = beep;
    res.last_was_working = previous_state_next;
    res.mode_after       = mode;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      handle_state   <= ST_ASLEEP;
      fault_state    <= FAULT_NONE;
      error_ticks    <= '0;
      sleep_ticks    <= '0;
      previous_state <= ST_ASLEEP;
    end else if (step) begin
      handle_state   <= handle_state_next;
      fault_state    <= fault_state_next;
      error_ticks    <= error_ticks_next;
      sleep_ticks    <= sleep_ticks_next;
      previous_state <= previous_state_next;
    end
  end

  // A long beep always means the handle went to sleep
  a_beep_sleeps: assert property (@(posedge clk) disable iff (rst)
    step && beep |=> handle_state == ST_ASLEEP && sleep_ticks == '0)
    else $error("beep without sleep");

  // A sleeping handle in normal operation leaves the error counter clear
  a_sleep_clears_err: assert property (@(posedge clk) disable iff (rst)
    step && cfg.operating_mode == OPMODE_NORMAL && handle_state == ST_ASLEEP
    |=> error_ticks == '0)
    else $error("error ticks not cleared while asleep");

  // Latched fault holds unless cleared
  a_fault_latched: assert property (@(posedge clk) disable iff (rst)
    step && !item.clear_fault && fault_state != FAULT_NONE |=> fault_state != FAULT_NONE)
    else $error("fault dropped without clear");

  // State holds between ticks
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(handle_state) && $stable(fault_state) && $stable(error_ticks))
    else $error("state changed without a tick");

endmodule

>>> rtl/core/heater_handle_supervisor_unit.sv
// Top level of the heater handle supervisor: input register, tick logic, result register.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one supervision tick per word:
//   handle position, temperature, airflow, heat mode, code-session flag and
//   a fault clear request. Output channel (out_valid/out_stall) returns one
//   result word per tick: handle state, fault code, long-beep pulse,
//   recorded previous state and heat mode after the tick.
//   A word accepted into the input register passes through the tick logic and
//   is in the result register when the output is free. Throughput: one word
//   per cycle while the output is free, limited by the state update in the
//   tick logic. Configuration is written through cfg_we/cfg_index/cfg_data
//   while the block is idle; the user must ensure this, as the block itself
//   does not enforce it. There is no read-back. Reset (rst, synchronous)
//   empties both stages, restores the configuration and state registers to
//   their defaults and puts the handle to sleep with no fault. When the
//   receiver stalls, the result word holds; the input register can still take
//   one more word, after which in_stall rises until the output drains.
module heater_handle_supervisor_unit
  import hhs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              handle_lifted,
  input  logic [SENS_W-1:0] temperature,
  input  logic [SENS_W-1:0] airflow,
  input  logic [1:0]        heat_mode,
  input  logic              code_session_active,
  input  logic              clear_fault,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              handle_active,
  output logic [1:0]        fault_code,
  output logic              long_beep,
  output logic              last_was_working,
  output logic [1:0]        mode_after
);

  hhs_cfg_t    cfg;
  hhs_item_t   s1_item;
  logic        s1_valid;
  hhs_result_t res;
  hhs_result_t out_word;
  logic        out_ready;
  logic        step;
  logic        in_take;

  // Handshake
  assign out_ready = !out_valid || !out_stall;
  assign step      = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign in_take   = in_valid && !in_stall;

  hhs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.handle_lifted       <= handle_lifted;
      s1_item.temperature         <= temperature;
      s1_item.airflow             <= airflow;
      s1_item.heat_mode           <= heat_mode;
      s1_item.code_session_active <= code_session_active;
      s1_item.clear_fault         <= clear_fault;
    end
  end

  hhs_tick_logic u_tick (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cfg  (cfg),
    .item (s1_item),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word <= res;
    end
  end

  assign handle_active    = out_word.handle_active;
  assign fault_code       = out_word.fault_code;
  assign long_beep        = out_word.long_beep;
  assign last_was_working = out_word.last_was_working;
  assign mode_after       = out_word.mode_after;

endmodule
